@@ hdl/coalescing_work_dispatcher_assert.svh @@
// Assertion macros shared by the coalescing work dispatcher RTL.
`ifndef COALESCING_WORK_DISPATCHER_ASSERT_SVH
`define COALESCING_WORK_DISPATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cwd_pkg.sv @@
// Package with the shared types and codes of the coalescing work dispatcher.
`timescale 1ns / 1ps
package cwd_pkg;

  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_APPLY     = 3'd1,
    MODE_POST_KEY  = 3'd2,
    MODE_POST_TASK = 3'd3,
    MODE_FETCH     = 3'd4,
    MODE_RESUME    = 3'd5,
    MODE_DONE      = 3'd6,
    MODE_STOP      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_STOPPING  = 2'd1,
    STAT_BAD_LIMIT = 2'd2,
    STAT_TASK_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    GRANT_WAIT   = 2'd0,
    GRANT_KEY    = 2'd1,
    GRANT_TASK   = 2'd2,
    GRANT_RETIRE = 2'd3
  } grant_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic sweep;
  } cwd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic stop_req;
    logic clr_last;
  } cwd_sts_t;

  localparam int unsigned CfgWidth = 7;

endpackage

@@ hdl/cwd_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cwd_ctrl.sv @@
// Controller state machine that sequences requests, commits and mark clearing.
`timescale 1ns / 1ps
module cwd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cwd_pkg::cwd_sts_t sts_i,
  output cwd_pkg::cwd_cmd_t cmd_o
);
  import cwd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) state_d = sts_i.stop_req ? S_CLEAR : S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: cmd_o.sweep = 1'b1;
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_EXEC:  cmd_o.commit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/cwd_dp.sv @@
// Datapath: queues, mark stores, worker counts and the result register.
`timescale 1ns / 1ps
`include "coalescing_work_dispatcher_assert.svh"
module cwd_dp #(
  parameter int unsigned KEY_COUNT    = 256,
  parameter int unsigned TASK_DEPTH   = 64,
  parameter int unsigned WORKER_LIMIT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwd_pkg::cwd_cmd_t cmd_i,
  output cwd_pkg::cwd_sts_t sts_o,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        job_key_i,
  input  logic [31:0]       task_handle_i,
  input  logic              timed_out_i,
  input  logic [6:0]        pool_min_i,
  input  logic [6:0]        pool_max_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [6:0]        spawn_count_o,
  output logic              wake_one_o,
  output logic              wake_all_o,
  output logic [1:0]        grant_kind_o,
  output logic [7:0]        grant_key_o,
  output logic [31:0]       grant_task_o,
  output logic [6:0]        live_count_o,
  output logic [6:0]        idle_count_o
);
  import cwd_pkg::*;

  localparam int unsigned KW  = $clog2(KEY_COUNT);
  localparam int unsigned KFW = $clog2(KEY_COUNT + 1);
  localparam int unsigned TW  = $clog2(TASK_DEPTH);
  localparam int unsigned TFW = $clog2(TASK_DEPTH + 1);
  localparam int unsigned CW  = $clog2(WORKER_LIMIT + 1);
  localparam int unsigned MW  = (CW > CfgWidth) ? CW : CfgWidth;
  localparam int unsigned KXW = (KW > 8) ? KW : 8;

  // Key folding table: job key modulo the key count.
  logic [KW-1:0] key_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_key_tab
    localparam int unsigned KeyRem = g % KEY_COUNT;
    assign key_tab[g] = KW'(KeyRem);
  end

  // Request registers.
  mode_e         mode_q;
  logic [KW-1:0] key_q;
  logic [31:0]   task_q;
  logic          tmo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= key_tab[job_key_i];
      task_q <= task_handle_i;
      tmo_q  <= timed_out_i;
    end
  end

  // Control state.
  logic [KW-1:0]  rhead_q, rhead_d, rtail_q, rtail_d;
  logic [KFW-1:0] rfill_q, rfill_d;
  logic [TW-1:0]  thead_q, thead_d, ttail_q, ttail_d;
  logic [TFW-1:0] tfill_q, tfill_d;
  logic [CW-1:0]  live_q, live_d, idle_q, idle_d;
  logic           stopping_q, stopping_d, running_q, running_d;
  logic [KW-1:0]  clr_q;
  logic           out_valid_q;

  // Result registers.
  status_e        status_q;
  logic [6:0]     spawn_q;
  logic           wone_q, wall_q;
  grant_e         kind_q;
  logic [7:0]     gkey_q;
  logic [31:0]    gtask_q;
  logic [6:0]     livec_q, idlec_q;

  // Memory ports.
  logic           q_we, a_we, d_we, q_wd, a_wd, d_wd;
  logic [KW-1:0]  q_wa, a_wa, d_wa;
  logic           q_rd, a_rd, d_rd;
  logic           r_we, t_we;
  logic [KW-1:0]  r_rd;
  logic [31:0]    t_rd;

  cwd_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_queued (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .re_i(cmd_i.accept), .raddr_i(key_tab[job_key_i]), .rdata_o(q_rd)
  );
  cwd_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_active (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd),
    .re_i(cmd_i.accept), .raddr_i(key_tab[job_key_i]), .rdata_o(a_rd)
  );
  cwd_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_dirty (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .re_i(cmd_i.accept), .raddr_i(key_tab[job_key_i]), .rdata_o(d_rd)
  );
  cwd_ram #(.WIDTH(KW), .DEPTH(KEY_COUNT)) u_ready (
    .clk_i, .we_i(r_we), .waddr_i(rtail_q), .wdata_i(key_q),
    .re_i(cmd_i.accept), .raddr_i(rhead_q), .rdata_o(r_rd)
  );
  cwd_ram #(.WIDTH(32), .DEPTH(TASK_DEPTH)) u_task (
    .clk_i, .we_i(t_we), .waddr_i(ttail_q), .wdata_i(task_q),
    .re_i(cmd_i.accept), .raddr_i(thead_q), .rdata_o(t_rd)
  );

  // Limit checks, all in a common width.
  logic [MW-1:0] live_x, min_x, max_x, lim_x, room_x;
  logic          lim_ok, may_spawn;

  assign live_x    = MW'(live_q);
  assign min_x     = MW'(pool_min_i);
  assign max_x     = MW'(pool_max_i);
  assign lim_x     = MW'(WORKER_LIMIT);
  assign room_x    = lim_x - live_x;
  assign lim_ok    = (min_x != '0) && (max_x >= min_x) && (max_x <= lim_x);
  assign may_spawn = (live_x < max_x) && (live_x < lim_x);

  logic [KXW-1:0] gkey_x;
  assign gkey_x = KXW'(r_rd);

  // Per-request results.
  status_e       stat;
  grant_e        kind;
  logic [MW-1:0] sp;
  logic          wone, wall, enq, do_fetch, do_retire, do_stop;
  logic [7:0]    gkey;
  logic [31:0]   gtask;
  logic [CW-1:0] idle_b;
  logic [KFW-1:0] rfill_a;

  always_comb begin
    stat      = STAT_OK;
    kind      = GRANT_WAIT;
    sp        = '0;
    wone      = 1'b0;
    wall      = 1'b0;
    enq       = 1'b0;
    do_fetch  = 1'b0;
    do_retire = 1'b0;
    do_stop   = 1'b0;
    gkey      = '0;
    gtask     = '0;
    idle_b    = idle_q;
    rfill_a   = rfill_q;
    rhead_d   = rhead_q;
    rtail_d   = rtail_q;
    rfill_d   = rfill_q;
    thead_d   = thead_q;
    ttail_d   = ttail_q;
    tfill_d   = tfill_q;
    stopping_d = stopping_q;
    running_d  = running_q;
    q_we = 1'b0; q_wa = key_q; q_wd = 1'b0;
    a_we = 1'b0; a_wa = key_q; a_wd = 1'b0;
    d_we = 1'b0; d_wa = key_q; d_wd = 1'b0;
    r_we = 1'b0;
    t_we = 1'b0;

    if (cmd_i.commit) begin
      unique case (mode_q)
        MODE_START: begin
          if (!lim_ok) begin
            stat = STAT_BAD_LIMIT;
          end else if (!running_q) begin
            stopping_d = 1'b0;
            sp         = (min_x <= room_x) ? min_x : room_x;
            running_d  = 1'b1;
          end
        end
        MODE_APPLY: begin
          if (!lim_ok) begin
            stat = STAT_BAD_LIMIT;
          end else if (running_q) begin
            if (!stopping_q && (live_x < min_x)) sp = min_x - live_x;
            wall = 1'b1;
          end
        end
        MODE_POST_KEY: begin
          if (stopping_q) begin
            stat = STAT_STOPPING;
          end else begin
            if (a_rd) begin
              d_we = 1'b1;
              d_wd = 1'b1;
            end else if (!q_rd && (rfill_q < KFW'(KEY_COUNT))) begin
              enq = 1'b1;
            end
            rfill_a = enq ? KFW'(rfill_q + 1'b1) : rfill_q;
            if ((rfill_a != '0) && (idle_q == '0) && may_spawn) sp = MW'(1);
            wone = 1'b1;
          end
        end
        MODE_POST_TASK: begin
          if (stopping_q) begin
            stat = STAT_STOPPING;
          end else if (tfill_q >= TFW'(TASK_DEPTH)) begin
            stat = STAT_TASK_FULL;
          end else begin
            t_we    = 1'b1;
            ttail_d = (ttail_q == TW'(TASK_DEPTH - 1)) ? '0 : TW'(ttail_q + 1'b1);
            tfill_d = TFW'(tfill_q + 1'b1);
            if ((idle_q == '0) && may_spawn) sp = MW'(1);
            wone = 1'b1;
          end
        end
        MODE_FETCH: do_fetch = 1'b1;
        MODE_RESUME: begin
          if (idle_q != '0) idle_b = CW'(idle_q - 1'b1);
          if (tmo_q && (rfill_q == '0) && (tfill_q == '0) && (live_x > min_x)) begin
            do_retire = 1'b1;
          end else begin
            do_fetch = 1'b1;
          end
        end
        MODE_DONE: begin
          a_we = 1'b1;
          a_wd = 1'b0;
          if (!stopping_q && d_rd) begin
            d_we = 1'b1;
            d_wd = 1'b0;
            if (!q_rd && (rfill_q < KFW'(KEY_COUNT))) begin
              enq  = 1'b1;
              wone = 1'b1;
            end
          end
        end
        MODE_STOP: begin
          do_stop    = 1'b1;
          stopping_d = 1'b1;
          running_d  = 1'b0;
          rhead_d    = '0;
          rtail_d    = '0;
          rfill_d    = '0;
          thead_d    = '0;
          ttail_d    = '0;
          tfill_d    = '0;
          wall       = 1'b1;
        end
      endcase

      if (do_fetch) begin
        priority if (stopping_q) begin
          do_retire = 1'b1;
        end else if (tfill_q != '0) begin
          gtask   = t_rd;
          thead_d = (thead_q == TW'(TASK_DEPTH - 1)) ? '0 : TW'(thead_q + 1'b1);
          tfill_d = TFW'(tfill_q - 1'b1);
          kind    = GRANT_TASK;
        end else if (rfill_q != '0) begin
          rhead_d = (rhead_q == KW'(KEY_COUNT - 1)) ? '0 : KW'(rhead_q + 1'b1);
          rfill_d = KFW'(rfill_q - 1'b1);
          q_we = 1'b1; q_wa = r_rd; q_wd = 1'b0;
          a_we = 1'b1; a_wa = r_rd; a_wd = 1'b1;
          gkey = gkey_x[7:0];
          kind = GRANT_KEY;
        end else begin
          if (idle_b < CW'(WORKER_LIMIT)) idle_b = CW'(idle_b + 1'b1);
          kind = GRANT_WAIT;
        end
      end

      if (do_retire) kind = GRANT_RETIRE;

      if (enq) begin
        q_we    = 1'b1;
        q_wa    = key_q;
        q_wd    = 1'b1;
        r_we    = 1'b1;
        rtail_d = (rtail_q == KW'(KEY_COUNT - 1)) ? '0 : KW'(rtail_q + 1'b1);
        rfill_d = KFW'(rfill_q + 1'b1);
      end

      if (sp != '0) running_d = 1'b1;
    end

    // Clearing sweep owns the mark stores while it runs.
    if (cmd_i.sweep) begin
      q_we = 1'b1; q_wa = clr_q; q_wd = 1'b0;
      a_we = 1'b1; a_wa = clr_q; a_wd = 1'b0;
      d_we = 1'b1; d_wa = clr_q; d_wd = 1'b0;
    end
  end

  always_comb begin
    live_d = live_q;
    idle_d = idle_b;
    if (do_stop) begin
      live_d = '0;
      idle_d = '0;
    end else if (do_retire) begin
      if (live_q != '0) live_d = CW'(live_q - 1'b1);
    end else begin
      live_d = CW'(live_q + CW'(sp));
    end
  end

  logic [MW-1:0] live_dx, idle_dx;
  assign live_dx = MW'(live_d);
  assign idle_dx = MW'(idle_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhead_q     <= '0;
      rtail_q     <= '0;
      rfill_q     <= '0;
      thead_q     <= '0;
      ttail_q     <= '0;
      tfill_q     <= '0;
      live_q      <= '0;
      idle_q      <= '0;
      stopping_q  <= 1'b0;
      running_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rhead_q    <= rhead_d;
      rtail_q    <= rtail_d;
      rfill_q    <= rfill_d;
      thead_q    <= thead_d;
      ttail_q    <= ttail_d;
      tfill_q    <= tfill_d;
      live_q     <= live_d;
      idle_q     <= idle_d;
      stopping_q <= stopping_d;
      running_q  <= running_d;
      if (cmd_i.sweep) begin
        clr_q <= (clr_q == KW'(KEY_COUNT - 1)) ? '0 : KW'(clr_q + 1'b1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= stat;
      spawn_q  <= sp[6:0];
      wone_q   <= wone;
      wall_q   <= wall;
      kind_q   <= kind;
      gkey_q   <= gkey;
      gtask_q  <= gtask;
      livec_q  <= live_dx[6:0];
      idlec_q  <= idle_dx[6:0];
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.stop_req = (mode_q == MODE_STOP);
  assign sts_o.clr_last = (clr_q == KW'(KEY_COUNT - 1));

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign spawn_count_o = spawn_q;
  assign wake_one_o    = wone_q;
  assign wake_all_o    = wall_q;
  assign grant_kind_o  = kind_q;
  assign grant_key_o   = gkey_q;
  assign grant_task_o  = gtask_q;
  assign live_count_o  = livec_q;
  assign idle_count_o  = idlec_q;

  `CWD_ASSERT_NEXT(a_stop_empties, cmd_i.commit && (mode_q == MODE_STOP), (rfill_q == '0) && (tfill_q == '0) && (live_q == '0), "stop left queued work or live workers")
  `CWD_ASSERT_NEXT(a_hold_without_commit, !cmd_i.commit, $stable(live_q) && $stable(idle_q) && $stable(tfill_q) && $stable(rfill_q), "counts changed without a request")
  `CWD_ASSERT_NEXT(a_key_grant_pops, cmd_i.commit && (mode_q == MODE_FETCH) && !stopping_q && (tfill_q == '0) && (rfill_q != '0), rfill_q == KFW'($past(rfill_q) - 1'b1), "key grant did not pop the ready queue")

endmodule

@@ hdl/coalescing_work_dispatcher.sv @@
// Top level of the coalescing work dispatcher: ports, limit registers, wiring.
`timescale 1ns / 1ps
// The dispatcher serves keyed jobs and plain tasks to an elastic worker pool.
// Requests enter on the input channel (in_valid_i / in_stall_o) and each one
// yields exactly one result on the output channel (out_valid_o / out_stall_i).
// A request is taken when valid is high and stall is low at a rising edge.
// The lower and upper pool size limits sit behind an APB-style port at byte
// addresses 0 and 4; write them only while no request is in flight.
// Each request is handled in a read step and an update step: the first reads
// the mark stores and queue heads from their memories, the second updates
// them and loads the result register. A new request is taken only once the
// previous one has been committed, so requests never overlap. If the receiver
// stalls, the finished result waits in the output register; the next request
// may be taken, but it is not committed until the held result has been taken.
// After reset, and after every stop request, the block sweeps the three key
// mark stores to zero, one key per cycle, covering all KEY_COUNT keys. The
// input channel stalls during the sweep; a stop's own result is still
// delivered and limit writes are still taken.
module coalescing_work_dispatcher #(
  parameter int unsigned KEY_COUNT    = 256,
  parameter int unsigned TASK_DEPTH   = 64,
  parameter int unsigned WORKER_LIMIT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  job_key_i,
  input  logic [31:0] task_handle_i,
  input  logic        timed_out_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  spawn_count_o,
  output logic        wake_one_o,
  output logic        wake_all_o,
  output logic [1:0]  grant_kind_o,
  output logic [7:0]  grant_key_o,
  output logic [31:0] grant_task_o,
  output logic [6:0]  live_count_o,
  output logic [6:0]  idle_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cwd_pkg::*;

  // Limit registers. Bit 2 of the address selects the register.
  logic [6:0] min_q, max_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 7'd1;
      max_q <= 7'd1;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        max_q <= pwdata[6:0];
      end else begin
        min_q <= pwdata[6:0];
      end
    end
  end

  assign prdata = paddr[2] ? {25'd0, max_q} : {25'd0, min_q};

  // Controller and datapath talk only through the command and status bundles.
  cwd_cmd_t cmd;
  cwd_sts_t sts;

  cwd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  cwd_dp #(
    .KEY_COUNT    (KEY_COUNT),
    .TASK_DEPTH   (TASK_DEPTH),
    .WORKER_LIMIT (WORKER_LIMIT)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i,
    .job_key_i,
    .task_handle_i,
    .timed_out_i,
    .pool_min_i    (min_q),
    .pool_max_i    (max_q),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .spawn_count_o,
    .wake_one_o,
    .wake_all_o,
    .grant_kind_o,
    .grant_key_o,
    .grant_task_o,
    .live_count_o,
    .idle_count_o
  );

endmodule
